// ----- rtl/stunmp_pkg.sv -----
package stunmp_pkg;

   // Message framing constants.
   localparam int unsigned HEADER_BYTES = 20;
   localparam int unsigned COUNT_WIDTH  = 17;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Attribute types that raise a flag when fully present.
   localparam logic [15:0] ATTR_NOMINATION  = 16'h0025;
   localparam logic [15:0] ATTR_CONTROLLED  = 16'h8029;
   localparam logic [15:0] ATTR_CONTROLLING = 16'h802A;

   // Bit positions in the seen flags.
   localparam int unsigned FLAG_NOMINATION  = 0;
   localparam int unsigned FLAG_CONTROLLED  = 1;
   localparam int unsigned FLAG_CONTROLLING = 2;

   // Result status codes; SHORT takes precedence over MISMATCH, which takes precedence over OVERRUN.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_OVERRUN  = 2'd3
   } status_type;

   // Parser phase while walking the header and the attributes.
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TYPE_HI = 3'd1,
      PH_TYPE_LO = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_VALUE   = 3'd5,
      PH_PAD     = 3'd6,
      PH_STOP    = 3'd7
   } phase_type;

endpackage

// ----- rtl/stun_message_parser_top.sv -----
// A result appears on rsp_ in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle unless held off as below; the parser registers take a small update per byte.
// A byte is held off only while a finished result waits and the result side stalls.
// Reset is synchronous and active high; it clears the parser state and the result valid.
// After every last byte the parser returns to its reset state for the next message.
module stun_message_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_msg_type,
   output logic [31:0] rsp_transaction_high,
   output logic [63:0] rsp_transaction_low,
   output logic        rsp_nominated,
   output logic        rsp_controlled,
   output logic        rsp_controlling
);
   import stunmp_pkg::*;

   // Parser state.
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [15:0]            decl_len_ff, decl_len_in;
   logic [15:0]            type_ff, type_in;
   logic [31:0]            tid_high_ff, tid_high_in;
   logic [63:0]            tid_low_ff, tid_low_in;
   phase_type              phase_ff, phase_in;
   logic [15:0]            attr_code_ff, attr_code_in;
   logic [15:0]            value_rem_ff, value_rem_in;
   logic [1:0]             pad_rem_ff, pad_rem_in;
   logic [2:0]             seen_ff, seen_in;
   logic                   overrun_ff, overrun_in;

   // Result register.
   logic        out_valid_ff;
   status_type  out_status_ff, out_status_in;
   logic [15:0] out_type_ff, out_type_in;
   logic [31:0] out_tid_high_ff, out_tid_high_in;
   logic [63:0] out_tid_low_ff, out_tid_low_in;
   logic [2:0]  out_flags_ff, out_flags_in;

   logic                   req_accept;
   logic                   rsp_accept;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [COUNT_WIDTH-1:0] limit;
   logic [COUNT_WIDTH-1:0] room;
   logic [COUNT_WIDTH-1:0] attr_len;
   logic [15:0]            value_dec;
   logic [1:0]             pad_dec;
   logic [4:0]             pos;

   // Handshakes: the input waits only when a held result cannot leave.
   assign req_stall  = out_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = out_valid_ff & ~rsp_stall;

   // Byte position and attribute-length arithmetic.
   assign new_count = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign pos       = count_ff[4:0];
   assign limit     = COUNT_WIDTH'(HEADER_BYTES) + {1'b0, decl_len_ff};
   assign room      = (new_count <= limit) ? limit - new_count : '0;
   assign attr_len  = {1'b0, value_rem_ff[15:8], req_data_byte};
   assign value_dec = value_rem_ff - 16'd1;
   assign pad_dec   = pad_rem_ff - 2'd1;

   // Next parser state for the byte on the input.
   always_comb begin
      count_in     = new_count;
      decl_len_in  = decl_len_ff;
      type_in      = type_ff;
      tid_high_in  = tid_high_ff;
      tid_low_in   = tid_low_ff;
      phase_in     = phase_ff;
      attr_code_in = attr_code_ff;
      value_rem_in = value_rem_ff;
      pad_rem_in   = pad_rem_ff;
      seen_in      = seen_ff;
      overrun_in   = overrun_ff;
      if (count_ff < COUNT_WIDTH'(HEADER_BYTES)) begin
         // Header bytes: type, length, cookie (ignored), transaction id.
         if (pos == 5'd0) begin
            type_in = {req_data_byte, 8'h00};
         end else if (pos == 5'd1) begin
            type_in = {type_ff[15:8], req_data_byte};
         end else if (pos == 5'd2) begin
            decl_len_in = {req_data_byte, 8'h00};
         end else if (pos == 5'd3) begin
            decl_len_in = {decl_len_ff[15:8], req_data_byte};
         end else if (pos >= 5'd8 && pos < 5'd12) begin
            tid_high_in = {tid_high_ff[23:0], req_data_byte};
         end else if (pos >= 5'd12) begin
            tid_low_in = {tid_low_ff[55:0], req_data_byte};
         end
         if (pos == 5'(HEADER_BYTES - 1)) begin
            phase_in = PH_TYPE_HI;
         end
      end else begin
         // Attribute walk.
         unique case (phase_ff)
            PH_TYPE_HI: begin
               attr_code_in = {req_data_byte, 8'h00};
               phase_in     = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
               attr_code_in = {attr_code_ff[15:8], req_data_byte};
               phase_in     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               value_rem_in = {req_data_byte, 8'h00};
               phase_in     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (attr_len > room) begin
                  overrun_in = 1'b1;
                  phase_in   = PH_STOP;
               end else begin
                  if (attr_code_ff == ATTR_NOMINATION) begin
                     seen_in[FLAG_NOMINATION] = 1'b1;
                  end else if (attr_code_ff == ATTR_CONTROLLED) begin
                     seen_in[FLAG_CONTROLLED] = 1'b1;
                  end else if (attr_code_ff == ATTR_CONTROLLING) begin
                     seen_in[FLAG_CONTROLLING] = 1'b1;
                  end
                  value_rem_in = attr_len[15:0];
                  pad_rem_in   = 2'd0 - attr_len[1:0];
                  phase_in     = (attr_len != '0) ? PH_VALUE : PH_TYPE_HI;
               end
            end
            PH_VALUE: begin
               value_rem_in = value_dec;
               if (value_dec == 16'd0) begin
                  phase_in = (pad_rem_ff != 2'd0) ? PH_PAD : PH_TYPE_HI;
               end
            end
            PH_PAD: begin
               pad_rem_in = pad_dec;
               if (pad_dec == 2'd0) begin
                  phase_in = PH_TYPE_HI;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result for a last byte, built from the updated state.
   always_comb begin
      if (count_in < COUNT_WIDTH'(HEADER_BYTES)) begin
         out_status_in = STATUS_SHORT;
      end else if (count_in != COUNT_WIDTH'(HEADER_BYTES) + {1'b0, decl_len_in}) begin
         out_status_in = STATUS_MISMATCH;
      end else if (overrun_in) begin
         out_status_in = STATUS_OVERRUN;
      end else begin
         out_status_in = STATUS_OK;
      end
      out_type_in     = (out_status_in == STATUS_SHORT) ? 16'd0 : type_in;
      out_tid_high_in = (out_status_in == STATUS_SHORT) ? 32'd0 : tid_high_in;
      out_tid_low_in  = (out_status_in == STATUS_SHORT) ? 64'd0 : tid_low_in;
      out_flags_in    = (out_status_in == STATUS_SHORT || out_status_in == STATUS_MISMATCH)
                        ? 3'd0 : seen_in;
   end

   // Parser registers; a last byte returns them to the reset state.
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_last)) begin
         count_ff     <= '0;
         decl_len_ff  <= '0;
         type_ff      <= '0;
         tid_high_ff  <= '0;
         tid_low_ff   <= '0;
         phase_ff     <= PH_HEADER;
         attr_code_ff <= '0;
         value_rem_ff <= '0;
         pad_rem_ff   <= '0;
         seen_ff      <= '0;
         overrun_ff   <= 1'b0;
      end else if (req_accept) begin
         count_ff     <= count_in;
         decl_len_ff  <= decl_len_in;
         type_ff      <= type_in;
         tid_high_ff  <= tid_high_in;
         tid_low_ff   <= tid_low_in;
         phase_ff     <= phase_in;
         attr_code_ff <= attr_code_in;
         value_rem_ff <= value_rem_in;
         pad_rem_ff   <= pad_rem_in;
         seen_ff      <= seen_in;
         overrun_ff   <= overrun_in;
      end
   end

   // Result valid: set by a last-byte transfer, cleared once the result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_accept && req_last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_accept && req_last) begin
         out_status_ff   <= out_status_in;
         out_type_ff     <= out_type_in;
         out_tid_high_ff <= out_tid_high_in;
         out_tid_low_ff  <= out_tid_low_in;
         out_flags_ff    <= out_flags_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_msg_type         = out_type_ff;
   assign rsp_transaction_high = out_tid_high_ff;
   assign rsp_transaction_low  = out_tid_low_ff;
   assign rsp_nominated        = out_flags_ff[FLAG_NOMINATION];
   assign rsp_controlled       = out_flags_ff[FLAG_CONTROLLED];
   assign rsp_controlling      = out_flags_ff[FLAG_CONTROLLING];

endmodule

// ----- sim/stun_message_parser_top_tb.sv -----
module stun_message_parser_top_tb;
   import stunmp_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned PHASE_BYTES = 400;
   localparam logic [15:0] ATTR_USERNAME = 16'h0006;
   localparam logic [31:0] STUN_COOKIE   = 32'h2112A442;

   typedef struct packed {
      logic [7:0] data;
      logic       tail;
   } stream_byte_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] msg_type;
      logic [31:0] transaction_high;
      logic [63:0] transaction_low;
      logic        nominated;
      logic        controlled;
      logic        controlling;
   } parse_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_msg_type;
   logic [31:0] rsp_transaction_high;
   logic [63:0] rsp_transaction_low;
   logic        rsp_nominated;
   logic        rsp_controlled;
   logic        rsp_controlling;

   stream_byte_type  pending_bytes[$];
   parse_report_type pending_reports[$];
   logic [7:0]  msg_buf[$];
   int unsigned last_pad;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   logic        byte_taken = 1'b0;

   // Parser state kept by the testbench.
   logic [16:0] seen_count;
   logic [15:0] decl_len;
   logic [15:0] type_acc;
   logic [31:0] tid_high_acc;
   logic [63:0] tid_low_acc;
   phase_type   walk;
   logic [15:0] attr_type;
   logic [15:0] attr_left;
   logic [1:0]  pad_left;
   logic [2:0]  seen_flags;
   logic        overrun;

   stun_message_parser_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_transaction_high(rsp_transaction_high),
      .rsp_transaction_low (rsp_transaction_low),
      .rsp_nominated       (rsp_nominated),
      .rsp_controlled      (rsp_controlled),
      .rsp_controlling     (rsp_controlling)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic clear_parser();
      seen_count   = '0;
      decl_len     = '0;
      type_acc     = '0;
      tid_high_acc = '0;
      tid_low_acc  = '0;
      walk         = PH_HEADER;
      attr_type    = '0;
      attr_left    = '0;
      pad_left     = '0;
      seen_flags   = '0;
      overrun      = 1'b0;
   endtask

   // Advance the parser by one accepted byte; a final byte queues its report.
   task automatic parse_stun_byte(input logic [7:0] b, input logic tail);
      logic [16:0] pos;
      logic [16:0] nxt;
      logic [16:0] limit;
      logic [16:0] room;
      logic [15:0] len;
      parse_report_type rep;
      pos = seen_count;
      nxt = (pos == COUNT_MAX) ? pos : pos + 17'd1;

      // Header bytes fill the type, length and transaction id.
      if (pos < HEADER_BYTES) begin
         if (pos == 0) type_acc = {b, 8'h00};
         else if (pos == 1) type_acc[7:0] = b;
         else if (pos == 2) decl_len = {b, 8'h00};
         else if (pos == 3) decl_len[7:0] = b;
         else if (pos >= 8 && pos < 12) tid_high_acc = {tid_high_acc[23:0], b};
         else if (pos >= 12) tid_low_acc = {tid_low_acc[55:0], b};
         if (pos == HEADER_BYTES - 1) walk = PH_TYPE_HI;
      end else begin
         limit = 17'(HEADER_BYTES) + {1'b0, decl_len};
         case (walk)
            PH_TYPE_HI: begin
               attr_type = {b, 8'h00};
               walk = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
               attr_type[7:0] = b;
               walk = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               attr_left = {b, 8'h00};
               walk = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               // The value must fit inside the declared message length.
               len  = {attr_left[15:8], b};
               room = (nxt <= limit) ? limit - nxt : '0;
               if ({1'b0, len} > room) begin
                  overrun = 1'b1;
                  walk = PH_STOP;
               end else begin
                  if (attr_type == ATTR_NOMINATION)
                     seen_flags[FLAG_NOMINATION] = 1'b1;
                  else if (attr_type == ATTR_CONTROLLED)
                     seen_flags[FLAG_CONTROLLED] = 1'b1;
                  else if (attr_type == ATTR_CONTROLLING)
                     seen_flags[FLAG_CONTROLLING] = 1'b1;
                  attr_left = len;
                  pad_left  = 2'd0 - len[1:0];
                  walk = (len != 0) ? PH_VALUE : PH_TYPE_HI;
               end
            end
            PH_VALUE: begin
               attr_left = attr_left - 16'd1;
               if (attr_left == 0) walk = (pad_left != 0) ? PH_PAD : PH_TYPE_HI;
            end
            PH_PAD: begin
               pad_left = pad_left - 2'd1;
               if (pad_left == 0) walk = PH_TYPE_HI;
            end
            default: begin
            end
         endcase
      end
      seen_count = nxt;

      // Build the report for the final byte, then start over.
      if (tail) begin
         limit = 17'(HEADER_BYTES) + {1'b0, decl_len};
         if (nxt < HEADER_BYTES) rep.status = STATUS_SHORT;
         else if (nxt != limit) rep.status = STATUS_MISMATCH;
         else if (overrun) rep.status = STATUS_OVERRUN;
         else rep.status = STATUS_OK;
         rep.msg_type         = (rep.status == STATUS_SHORT) ? '0 : type_acc;
         rep.transaction_high = (rep.status == STATUS_SHORT) ? '0 : tid_high_acc;
         rep.transaction_low  = (rep.status == STATUS_SHORT) ? '0 : tid_low_acc;
         if (rep.status == STATUS_SHORT || rep.status == STATUS_MISMATCH) begin
            rep.nominated   = 1'b0;
            rep.controlled  = 1'b0;
            rep.controlling = 1'b0;
         end else begin
            rep.nominated   = seen_flags[FLAG_NOMINATION];
            rep.controlled  = seen_flags[FLAG_CONTROLLED];
            rep.controlling = seen_flags[FLAG_CONTROLLING];
         end
         pending_reports.push_back(rep);
         clear_parser();
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: rsp_%s expected %0h got %0h", $time, what, want, got);
      end
   endtask

   // Message assembly helpers.
   task automatic push_random_bytes(input int unsigned n);
      repeat (n) msg_buf.push_back(8'($urandom));
   endtask

   task automatic start_header(input logic [15:0] mtype, input logic [31:0] cookie,
                               input logic [95:0] tid);
      int i;
      msg_buf.delete();
      last_pad = 0;
      msg_buf.push_back(mtype[15:8]);
      msg_buf.push_back(mtype[7:0]);
      msg_buf.push_back(8'h00);
      msg_buf.push_back(8'h00);
      for (i = 3; i >= 0; i--) msg_buf.push_back(cookie[i*8 +: 8]);
      for (i = 11; i >= 0; i--) msg_buf.push_back(tid[i*8 +: 8]);
   endtask

   task automatic push_attr_header(input logic [15:0] code, input logic [15:0] len);
      msg_buf.push_back(code[15:8]);
      msg_buf.push_back(code[7:0]);
      msg_buf.push_back(len[15:8]);
      msg_buf.push_back(len[7:0]);
   endtask

   task automatic add_attribute(input logic [15:0] code, input int unsigned len);
      push_attr_header(code, 16'(len));
      push_random_bytes(len);
      last_pad = (4 - (len % 4)) % 4;
      push_random_bytes(last_pad);
   endtask

   task automatic commit_message();
      stream_byte_type sb;
      int i;
      for (i = 0; i < msg_buf.size(); i++) begin
         sb.data = msg_buf[i];
         sb.tail = (i == msg_buf.size() - 1);
         pending_bytes.push_back(sb);
      end
      bytes_queued += msg_buf.size();
   endtask

   // Write the declared length as the body size plus an offset, then queue it.
   task automatic seal_message(input int delta);
      logic [15:0] len;
      len = 16'(int'(msg_buf.size()) - 20 + delta);
      msg_buf[2] = len[15:8];
      msg_buf[3] = len[7:0];
      commit_message();
   endtask

   function automatic logic [15:0] random_attr_code();
      case ($urandom_range(7))
         0, 1: return ATTR_NOMINATION;
         2:    return ATTR_CONTROLLED;
         3:    return ATTR_CONTROLLING;
         4:    return ATTR_USERNAME;
         5:    return 16'h8028 + 16'($urandom_range(0, 3) * 2);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_message();
      int unsigned kind;
      int unsigned variant;
      int unsigned len;
      int unsigned extra;
      logic [15:0] code;
      kind = $urandom_range(99);
      if (kind < 8) begin
         // Too short to hold a header.
         msg_buf.delete();
         push_random_bytes($urandom_range(1, 19));
         commit_message();
      end else if (kind < 14) begin
         // Unstructured noise.
         msg_buf.delete();
         push_random_bytes($urandom_range(20, 64));
         commit_message();
      end else begin
         start_header(16'($urandom),
                      ($urandom_range(9) == 0) ? 32'($urandom) : STUN_COOKIE,
                      {32'($urandom), 32'($urandom), 32'($urandom)});
         repeat ($urandom_range(0, 4)) begin
            code = random_attr_code();
            if (code == ATTR_CONTROLLED || code == ATTR_CONTROLLING) len = 8;
            else if (code == ATTR_NOMINATION) len = 0;
            else len = $urandom_range(0, 20);
            if ($urandom_range(3) == 0) len = $urandom_range(0, 20);
            add_attribute(code, len);
         end
         variant = $urandom_range(99);
         if (variant < 55) begin
            seal_message(0);
         end else if (variant < 65) begin
            repeat (last_pad) void'(msg_buf.pop_back());
            seal_message(0);
         end else if (variant < 73) begin
            push_random_bytes($urandom_range(1, 3));
            seal_message(0);
         end else if (variant < 88) begin
            // Final attribute claims more value than the message holds.
            len   = $urandom_range(1, 40);
            extra = $urandom_range(0, len - 1);
            push_attr_header(random_attr_code(), 16'(len));
            push_random_bytes(extra);
            seal_message(0);
         end else begin
            extra = $urandom_range(1, 8);
            seal_message($urandom_range(1) ? int'(extra) : -int'(extra));
         end
      end
   endtask

   task automatic directed_messages();
      // A lone final byte, and a header one byte short.
      msg_buf.delete();
      msg_buf.push_back(8'hFF);
      commit_message();
      msg_buf.delete();
      repeat (19) msg_buf.push_back(8'hFF);
      commit_message();

      // Bare headers at both extremes of every field.
      start_header(16'hFFFF, 32'hFFFFFFFF, '1);
      seal_message(0);
      start_header(16'h0000, 32'h00000000, '0);
      seal_message(0);
      start_header(16'hFFFF, STUN_COOKIE, '1);
      seal_message(65535);

      // Declared attributes that never arrive.
      start_header(16'h0001, STUN_COOKIE, 96'h0123456789ABCDEF01234567);
      seal_message(4);

      // Each ICE attribute alone, then all of them after an unknown one.
      start_header(16'h0001, STUN_COOKIE, 96'h1);
      add_attribute(ATTR_NOMINATION, 0);
      seal_message(0);
      start_header(16'h0101, STUN_COOKIE, 96'h2);
      add_attribute(ATTR_CONTROLLED, 8);
      seal_message(0);
      start_header(16'h0111, STUN_COOKIE, 96'h3);
      add_attribute(ATTR_CONTROLLING, 8);
      seal_message(0);
      start_header(16'h0001, STUN_COOKIE, {32'hFFFFFFFF, 64'h0});
      add_attribute(ATTR_USERNAME, 9);
      add_attribute(ATTR_CONTROLLING, 8);
      add_attribute(ATTR_NOMINATION, 0);
      add_attribute(ATTR_CONTROLLED, 8);
      seal_message(0);

      // Codes next to the flagged ones are skipped.
      start_header(16'h0001, STUN_COOKIE, 96'h4);
      add_attribute(16'h0024, 4);
      add_attribute(16'h8028, 4);
      add_attribute(16'h802B, 4);
      add_attribute(16'h0026, 0);
      seal_message(0);

      // Overrun after a complete attribute keeps its flag.
      start_header(16'h0001, STUN_COOKIE, 96'h5);
      add_attribute(ATTR_CONTROLLING, 8);
      push_attr_header(ATTR_NOMINATION, 16'd100);
      push_random_bytes(4);
      seal_message(0);

      // Overrun hidden behind a length mismatch.
      start_header(16'h0001, STUN_COOKIE, 96'h6);
      add_attribute(ATTR_CONTROLLED, 8);
      push_attr_header(ATTR_USERNAME, 16'hFFFF);
      push_random_bytes(4);
      seal_message(4);

      // Value exactly fills the message and the final padding is missing.
      start_header(16'h0001, STUN_COOKIE, 96'h7);
      add_attribute(ATTR_USERNAME, 5);
      repeat (last_pad) void'(msg_buf.pop_back());
      seal_message(0);

      // Trailing partial attribute header.
      start_header(16'h0001, STUN_COOKIE, 96'h8);
      add_attribute(ATTR_CONTROLLED, 8);
      push_random_bytes(3);
      seal_message(0);

      // Message longer than declared drops the flags.
      start_header(16'h0001, STUN_COOKIE, 96'h9);
      add_attribute(ATTR_NOMINATION, 0);
      seal_message(-4);
   endtask

   // Run one traffic setting and let it drain completely.
   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input bit with_directed);
      int unsigned start;
      idle_pct  = idle;
      stall_pct = stall;
      start = bytes_queued;
      if (with_directed) directed_messages();
      while (bytes_queued - start < PHASE_BYTES) random_message();
      do @(negedge clock);
      while (bytes_accepted != bytes_queued || pending_reports.size() != 0);
   endtask

   // Byte sender: a new byte only once the current one has been taken.
   always @(negedge clock) begin : feed_bytes
      stream_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_byte = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_byte.data;
            req_last      <= next_byte.tail;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side backpressure.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Transfers on both channels, result checks and the watchdog.
   always @(posedge clock) begin : watch_ports
      parse_report_type want;
      if (reset) begin
         byte_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         byte_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            parse_stun_byte(req_data_byte, req_last);
            bytes_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               fail_count++;
               $display("%0t: result expected none got status %0h", $time, rsp_status);
            end else begin
               want = pending_reports.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("msg_type", 64'(want.msg_type), 64'(rsp_msg_type));
               check_field("transaction_high", 64'(want.transaction_high),
                           64'(rsp_transaction_high));
               check_field("transaction_low", want.transaction_low, rsp_transaction_low);
               check_field("nominated", 64'(want.nominated), 64'(rsp_nominated));
               check_field("controlled", 64'(want.controlled), 64'(rsp_controlled));
               check_field("controlling", 64'(want.controlling), 64'(rsp_controlling));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Each drain between settings also pauses the sender until all reports are in.
      run_phase(0, 0, 1'b1);
      run_phase(70, 0, 1'b0);
      run_phase(0, 70, 1'b0);
      run_phase(35, 35, 1'b0);
      run_phase(0, 0, 1'b0);

      repeat (4) @(negedge clock);
      if (pending_reports.size() != 0) begin
         fail_count += pending_reports.size();
         $display("%0t: %0d reports never arrived", $time, pending_reports.size());
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
